/* hdl/tbb_pkg.sv */
package tbb_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int AXES      = 3;
   localparam int NUM_REGS  = 2 * AXES;
   localparam int CSR_ADDR_W = 5;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   localparam logic [2:0] REG_LOCAL_MIN_X = 3'd0;
   localparam logic [2:0] REG_LOCAL_MIN_Y = 3'd1;
   localparam logic [2:0] REG_LOCAL_MIN_Z = 3'd2;
   localparam logic [2:0] REG_LOCAL_MAX_X = 3'd3;
   localparam logic [2:0] REG_LOCAL_MAX_Y = 3'd4;
   localparam logic [2:0] REG_LOCAL_MAX_Z = 3'd5;

   localparam word_type LOCAL_HALF = word_type'(64'sd1 <<< (FRAC_BITS - 1));

   localparam logic signed [63:0] START_WIDE = 64'sd9999 <<< FRAC_BITS;
   localparam word_type WORD_MAX  = 32'sh7fff_ffff;
   localparam word_type WORD_MIN  = 32'sh8000_0000;
   localparam word_type START_VAL = (START_WIDE > 64'sd2147483647) ? WORD_MAX
                                                                    : word_type'(START_WIDE);
   localparam word_type START_NEG = -START_VAL;

endpackage

/* hdl/transformed_box_bounds.sv */
// Maps the eight corners of a local axis-aligned box (six CSRs, signed fixed
// point with tbb_pkg::FRAC_BITS fraction bits) through the top three rows of
// an affine matrix given with each request item, and returns the world-space
// min, max and center per axis. Each coordinate is computed exactly, floored
// and saturated to 32 bits; the min never exceeds +9999 and the max never
// drops below -9999. The block accepts one item per clock unless a stalled
// result backs up the pipeline, and passes each through five register stages:
// products, term selection, row sum, floor and saturation, center. Stages
// advance independently, so a stalled result holds only the stages behind
// it. Write the CSRs only while no item is in flight.
module transformed_box_bounds (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tbb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tbb_pkg::word_type               req_m00,
   input  tbb_pkg::word_type               req_m01,
   input  tbb_pkg::word_type               req_m02,
   input  tbb_pkg::word_type               req_m03,
   input  tbb_pkg::word_type               req_m10,
   input  tbb_pkg::word_type               req_m11,
   input  tbb_pkg::word_type               req_m12,
   input  tbb_pkg::word_type               req_m13,
   input  tbb_pkg::word_type               req_m20,
   input  tbb_pkg::word_type               req_m21,
   input  tbb_pkg::word_type               req_m22,
   input  tbb_pkg::word_type               req_m23,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tbb_pkg::word_type               rsp_world_min_x,
   output tbb_pkg::word_type               rsp_world_min_y,
   output tbb_pkg::word_type               rsp_world_min_z,
   output tbb_pkg::word_type               rsp_world_max_x,
   output tbb_pkg::word_type               rsp_world_max_y,
   output tbb_pkg::word_type               rsp_world_max_z,
   output tbb_pkg::word_type               rsp_center_x,
   output tbb_pkg::word_type               rsp_center_y,
   output tbb_pkg::word_type               rsp_center_z
);

   localparam int AXES = tbb_pkg::AXES;

   function automatic tbb_pkg::word_type sat_word(input tbb_pkg::sum_type v);
      tbb_pkg::word_type r;
      if (v > tbb_pkg::sum_type'(tbb_pkg::WORD_MAX)) begin
         r = tbb_pkg::WORD_MAX;
      end else if (v < tbb_pkg::sum_type'(tbb_pkg::WORD_MIN)) begin
         r = tbb_pkg::WORD_MIN;
      end else begin
         r = tbb_pkg::word_type'(v);
      end
      return r;
   endfunction

   // CSRs
   tbb_pkg::word_type local_ff [tbb_pkg::NUM_REGS];
   logic [2:0]        csr_idx;
   logic              csr_wr;

   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            local_ff[i]        <= -tbb_pkg::LOCAL_HALF;
            local_ff[i + AXES] <= tbb_pkg::LOCAL_HALF;
         end
      end else if (csr_wr) begin
         unique case (csr_idx)
            tbb_pkg::REG_LOCAL_MIN_X: local_ff[0] <= csr_pwdata;
            tbb_pkg::REG_LOCAL_MIN_Y: local_ff[1] <= csr_pwdata;
            tbb_pkg::REG_LOCAL_MIN_Z: local_ff[2] <= csr_pwdata;
            tbb_pkg::REG_LOCAL_MAX_X: local_ff[3] <= csr_pwdata;
            tbb_pkg::REG_LOCAL_MAX_Y: local_ff[4] <= csr_pwdata;
            tbb_pkg::REG_LOCAL_MAX_Z: local_ff[5] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         tbb_pkg::REG_LOCAL_MIN_X: csr_prdata = local_ff[0];
         tbb_pkg::REG_LOCAL_MIN_Y: csr_prdata = local_ff[1];
         tbb_pkg::REG_LOCAL_MIN_Z: csr_prdata = local_ff[2];
         tbb_pkg::REG_LOCAL_MAX_X: csr_prdata = local_ff[3];
         tbb_pkg::REG_LOCAL_MAX_Y: csr_prdata = local_ff[4];
         tbb_pkg::REG_LOCAL_MAX_Z: csr_prdata = local_ff[5];
         default:                  csr_prdata = '0;
      endcase
   end

   // Stage handshake
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   assign en5       = !v5_ff || rsp_ready;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // Stage 1: each coefficient times the low and high bound of its axis
   tbb_pkg::word_type mat [AXES][AXES+1];
   tbb_pkg::prod_type prod_lo_in [AXES][AXES], prod_lo_ff [AXES][AXES];
   tbb_pkg::prod_type prod_hi_in [AXES][AXES], prod_hi_ff [AXES][AXES];
   tbb_pkg::word_type trans1_ff [AXES];

   assign mat[0][0] = req_m00;
   assign mat[0][1] = req_m01;
   assign mat[0][2] = req_m02;
   assign mat[0][3] = req_m03;
   assign mat[1][0] = req_m10;
   assign mat[1][1] = req_m11;
   assign mat[1][2] = req_m12;
   assign mat[1][3] = req_m13;
   assign mat[2][0] = req_m20;
   assign mat[2][1] = req_m21;
   assign mat[2][2] = req_m22;
   assign mat[2][3] = req_m23;

   always_comb begin
      for (int r = 0; r < AXES; r++) begin
         for (int c = 0; c < AXES; c++) begin
            prod_lo_in[r][c] = mat[r][c] * local_ff[c];
            prod_hi_in[r][c] = mat[r][c] * local_ff[c + AXES];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         for (int r = 0; r < AXES; r++) begin
            trans1_ff[r] <= mat[r][AXES];
         end
      end
   end

   // Stage 2: corners are all bound combinations, so the extreme sum takes
   // the extreme of each term
   tbb_pkg::prod_type tmin_in [AXES][AXES], tmin_ff [AXES][AXES];
   tbb_pkg::prod_type tmax_in [AXES][AXES], tmax_ff [AXES][AXES];
   tbb_pkg::word_type trans2_ff [AXES];

   always_comb begin
      for (int r = 0; r < AXES; r++) begin
         for (int c = 0; c < AXES; c++) begin
            if (prod_lo_ff[r][c] < prod_hi_ff[r][c]) begin
               tmin_in[r][c] = prod_lo_ff[r][c];
               tmax_in[r][c] = prod_hi_ff[r][c];
            end else begin
               tmin_in[r][c] = prod_hi_ff[r][c];
               tmax_in[r][c] = prod_lo_ff[r][c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         tmin_ff   <= tmin_in;
         tmax_ff   <= tmax_in;
         trans2_ff <= trans1_ff;
      end
   end

   // Stage 3: exact row sums with the translation aligned to the products
   tbb_pkg::sum_type smin_in [AXES], smin_ff [AXES];
   tbb_pkg::sum_type smax_in [AXES], smax_ff [AXES];

   always_comb begin
      for (int r = 0; r < AXES; r++) begin
         smin_in[r] = tbb_pkg::sum_type'(tmin_ff[r][0]) + tbb_pkg::sum_type'(tmin_ff[r][1])
                    + tbb_pkg::sum_type'(tmin_ff[r][2])
                    + (tbb_pkg::sum_type'(trans2_ff[r]) <<< tbb_pkg::FRAC_BITS);
         smax_in[r] = tbb_pkg::sum_type'(tmax_ff[r][0]) + tbb_pkg::sum_type'(tmax_ff[r][1])
                    + tbb_pkg::sum_type'(tmax_ff[r][2])
                    + (tbb_pkg::sum_type'(trans2_ff[r]) <<< tbb_pkg::FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         smin_ff <= smin_in;
         smax_ff <= smax_in;
      end
   end

   // Stage 4: floor, saturate, clamp against the start values
   tbb_pkg::word_type mn_in [AXES], mn_ff [AXES];
   tbb_pkg::word_type mx_in [AXES], mx_ff [AXES];
   tbb_pkg::word_type vmin, vmax;

   always_comb begin
      vmin = '0;
      vmax = '0;
      for (int r = 0; r < AXES; r++) begin
         vmin      = sat_word(smin_ff[r] >>> tbb_pkg::FRAC_BITS);
         vmax      = sat_word(smax_ff[r] >>> tbb_pkg::FRAC_BITS);
         mn_in[r]  = (vmin < tbb_pkg::START_VAL) ? vmin : tbb_pkg::START_VAL;
         mx_in[r]  = (vmax > tbb_pkg::START_NEG) ? vmax : tbb_pkg::START_NEG;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         mn_ff <= mn_in;
         mx_ff <= mx_in;
      end
   end

   // Stage 5: output register with the floored center
   logic signed [tbb_pkg::WORD_W:0] csum [AXES];
   tbb_pkg::word_type omin_ff [AXES], omax_ff [AXES], octr_ff [AXES];

   always_comb begin
      for (int r = 0; r < AXES; r++) begin
         csum[r] = (tbb_pkg::WORD_W+1)'(mn_ff[r]) + (tbb_pkg::WORD_W+1)'(mx_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         omin_ff <= mn_ff;
         omax_ff <= mx_ff;
         for (int r = 0; r < AXES; r++) begin
            octr_ff[r] <= csum[r][tbb_pkg::WORD_W:1];
         end
      end
   end

   assign rsp_world_min_x = omin_ff[0];
   assign rsp_world_min_y = omin_ff[1];
   assign rsp_world_min_z = omin_ff[2];
   assign rsp_world_max_x = omax_ff[0];
   assign rsp_world_max_y = omax_ff[1];
   assign rsp_world_max_z = omax_ff[2];
   assign rsp_center_x    = octr_ff[0];
   assign rsp_center_y    = octr_ff[1];
   assign rsp_center_z    = octr_ff[2];

endmodule

/* hdl/tbb_checker.sv */
module tbb_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_ready,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  tbb_pkg::word_type               rsp_world_min_x,
   input  tbb_pkg::word_type               rsp_world_max_x,
   input  tbb_pkg::word_type               rsp_center_x
);

   logic signed [tbb_pkg::WORD_W:0] sum_x;

   assign sum_x = (tbb_pkg::WORD_W+1)'(rsp_world_min_x) + (tbb_pkg::WORD_W+1)'(rsp_world_max_x);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output stage is empty");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_world_min_x)
                                 && $stable(rsp_world_max_x))
      else $error("stalled item changed");

   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_world_min_x <= tbb_pkg::START_VAL
                    && rsp_world_max_x >= tbb_pkg::START_NEG)
      else $error("bounds outside start clamp");

   a_center: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_center_x == sum_x[tbb_pkg::WORD_W:1])
      else $error("center does not match bounds");

endmodule

bind transformed_box_bounds tbb_checker u_tbb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_world_min_x (rsp_world_min_x),
   .rsp_world_max_x (rsp_world_max_x),
   .rsp_center_x    (rsp_center_x)
);
